FILE: rtl/fud_pkg.sv
// ----------------------------------------------------------------------------
// fud_pkg
// Shared types and constants of the form-urlencoded decoder: result and state
// records, result kinds, special characters and result queue sizing.
// ----------------------------------------------------------------------------
package fud_pkg;

  // Result kinds
  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_VALUE   = 2'd1;
  localparam logic [1:0] KIND_ACCEPT  = 2'd2;
  localparam logic [1:0] KIND_DISCARD = 2'd3;

  // Special characters
  localparam logic [7:0] CHAR_AMP     = 8'h26;  // '&'
  localparam logic [7:0] CHAR_EQUAL   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CHAR_SPACE   = 8'h20;  // ' '

  // Escape phases
  localparam logic [1:0] ESC_IDLE  = 2'd0;
  localparam logic [1:0] ESC_PCT   = 2'd1;
  localparam logic [1:0] ESC_DIGIT = 2'd2;

  // Results caused by one request, at most
  localparam int MAX_RES = 4;
  localparam int RES_N_W = $clog2(MAX_RES + 1);
  localparam int RES_I_W = $clog2(MAX_RES);

  // Result queue
  localparam int QUEUE_DEPTH = 8;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } fud_res_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] held;
    logic       after_equal;
    logic       token_open;
  } fud_state_t;

  typedef struct packed {
    logic valid;  // queue holds a result
    logic room;   // queue can take a full request's results
  } fud_qstat_t;

endpackage

FILE: rtl/fud_decode.sv
// ----------------------------------------------------------------------------
// fud_decode
// Single-pass decode of one raw body byte: next token/escape state and the
// ordered list of results the byte causes.
// ----------------------------------------------------------------------------
module fud_decode (
  input  fud_pkg::fud_state_t                 state,
  input  logic [7:0]                          in_byte,
  input  logic                                in_last,
  output fud_pkg::fud_state_t                 state_next,
  output logic [fud_pkg::RES_N_W-1:0]         res_n,
  output fud_pkg::fud_res_t [fud_pkg::MAX_RES-1:0] res
);
  import fud_pkg::*;

  typedef struct packed {
    fud_state_t                  st;
    logic [RES_N_W-1:0]          n;
    fud_res_t [MAX_RES-1:0]      r;
  } work_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
    else v = c - "A" + 8'd10;
    return v[3:0];
  endfunction

  function automatic work_t put(input work_t w, input logic [7:0] b, input logic [1:0] k);
    work_t o;
    o = w;
    if (w.n < RES_N_W'(MAX_RES)) begin
      o.r[w.n[RES_I_W-1:0]] = '{data: b, kind: k, last: 1'b0};
      o.n = w.n + 1'b1;
    end
    return o;
  endfunction

  function automatic work_t emit(input work_t w, input logic [7:0] d);
    work_t o;
    o = w;
    if (!w.st.after_equal && d == CHAR_EQUAL) begin
      o.st.after_equal = 1'b1;
    end else begin
      o = put(w, d, w.st.after_equal ? KIND_VALUE : KIND_NAME);
    end
    return o;
  endfunction

  function automatic work_t flush(input work_t w);
    work_t o;
    o = w;
    if (w.st.phase == ESC_PCT) begin
      o = emit(o, CHAR_PERCENT);
    end else if (w.st.phase == ESC_DIGIT) begin
      o = emit(o, CHAR_PERCENT);
      o = emit(o, w.st.held);
    end
    o.st.phase = ESC_IDLE;
    o.st.held  = 8'h00;
    return o;
  endfunction

  function automatic work_t close_tok(input work_t w);
    work_t o;
    o = w;
    if (w.st.token_open) begin
      o = put(o, 8'h00, w.st.after_equal ? KIND_ACCEPT : KIND_DISCARD);
    end
    o.st.token_open  = 1'b0;
    o.st.after_equal = 1'b0;
    return o;
  endfunction

  function automatic work_t plain(input work_t w, input logic [7:0] b);
    work_t o;
    o = w;
    if (b == CHAR_AMP) begin
      o = close_tok(o);
    end else begin
      o.st.token_open = 1'b1;
      if (b == CHAR_PERCENT) o.st.phase = ESC_PCT;
      else if (b == CHAR_PLUS) o = emit(o, CHAR_SPACE);
      else o = emit(o, b);
    end
    return o;
  endfunction

  work_t w;

  always_comb begin
    w    = '0;
    w.st = state;
    if (state.phase == ESC_PCT && is_hex(in_byte)) begin
      w.st.held  = in_byte;
      w.st.phase = ESC_DIGIT;
    end else if (state.phase == ESC_DIGIT && is_hex(in_byte)) begin
      w.st.phase = ESC_IDLE;
      w.st.held  = 8'h00;
      w = emit(w, {hex_val(state.held), hex_val(in_byte)});
    end else begin
      w = flush(w);
      w = plain(w, in_byte);
    end
    if (in_last) begin
      w = flush(w);
      w = close_tok(w);
    end
    // mark the final result of this request
    for (int i = 0; i < MAX_RES; i++) begin
      if (RES_N_W'(i + 1) == w.n) w.r[i].last = 1'b1;
    end
  end

  assign state_next = w.st;
  assign res_n      = w.n;
  assign res        = w.r;

endmodule

FILE: rtl/fud_queue.sv
// ----------------------------------------------------------------------------
// fud_queue
// Collapsing result queue: takes up to a full request's results in a cycle,
// hands out one result a cycle while pop is high, from the head slot.
// ----------------------------------------------------------------------------
module fud_queue (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  input  logic [fud_pkg::RES_N_W-1:0]              push_n,
  input  fud_pkg::fud_res_t [fud_pkg::MAX_RES-1:0] push_res,
  input  logic                                     pop,
  output fud_pkg::fud_res_t                        head,
  output fud_pkg::fud_qstat_t                      stat
);
  import fud_pkg::*;

  fud_res_t              slot      [QUEUE_DEPTH];
  fud_res_t              slot_next [QUEUE_DEPTH];
  logic [QCNT_W-1:0]     count;
  logic [QCNT_W-1:0]     count_next;
  logic [QCNT_W-1:0]     base;
  logic [QCNT_W-1:0]     off;

  always_comb begin
    base = count - QCNT_W'(pop);
    off  = '0;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (pop && j < QUEUE_DEPTH - 1) slot_next[j] = slot[j + 1];
      else slot_next[j] = slot[j];
      off = QCNT_W'(j) - base;
      if (push && QCNT_W'(j) >= base && off < QCNT_W'(push_n)) begin
        slot_next[j] = push_res[off[RES_I_W-1:0]];
      end
    end
    count_next = base + (push ? QCNT_W'(push_n) : QCNT_W'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QUEUE_DEPTH; j++) slot[j] <= slot_next[j];
  end

  assign head       = slot[0];
  assign stat.valid = (count != '0);
  assign stat.room  = (count <= QCNT_W'(QUEUE_DEPTH - MAX_RES));

endmodule

FILE: rtl/form_urlencoded_decoder_core.sv
// ----------------------------------------------------------------------------
// form_urlencoded_decoder_core
// Streaming decoder for form-urlencoded bodies: splits tokens at '&', decodes
// '+' and percent escapes, tags bytes as name or value, closes each token.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one raw body byte per request, with
//   in_last on the final byte of the body. Output channel (out_valid /
//   out_stall): one result per request - a decoded byte tagged name or value,
//   or a token marker (pair accepted / token discarded), with out_last on the
//   last result caused by an input byte. An input byte causes zero to four
//   results.
//   With the queue empty, a result is presented the cycle after its input
//   byte is taken; queued results ahead of it are handed out first.
//   Throughput: one input byte per cycle while the consumer keeps up; the
//   output drains one result per cycle, so escape flushes and markers
//   (several results from one byte) slow the input only once the 8-entry
//   result queue holds more than four results.
//   in_stall rises when the queue cannot take a worst-case burst of four.
//   A stalled consumer holds the head result steady; the queue then fills
//   and stalls the input. Reset clears the queue and the token and escape
//   state: the first byte after reset starts a new token in its name part.
// ----------------------------------------------------------------------------
module form_urlencoded_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       out_last
);
  import fud_pkg::*;

  fud_state_t               state;
  fud_state_t               state_next;
  logic [RES_N_W-1:0]       res_n;
  fud_res_t [MAX_RES-1:0]   res;
  fud_res_t                 head;
  fud_qstat_t               qstat;
  logic                     accept;
  logic                     pop;

  // take a request only when the queue can hold all it may cause
  assign in_stall = !qstat.room;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  // decode the incoming byte against the current token state
  fud_decode u_decode (
    .state      (state),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .state_next (state_next),
    .res_n      (res_n),
    .res        (res)
  );

  // advance token and escape state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // queue results; drop nothing, drain one per cycle while out_stall is low
  fud_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_n   (res_n),
    .push_res (res),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  assign out_valid = qstat.valid;
  assign out_byte  = head.data;
  assign kind      = head.kind;
  assign out_last  = head.last;

endmodule

FILE: test/tb_form_urlencoded_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_form_urlencoded_decoder_core
// Self-checking bench for the form-urlencoded decoder. A scoreboard tracks the
// token and escape state, predicts the tagged results of every accepted
// request and checks each result that leaves the block, in order.
// ----------------------------------------------------------------------------
import fud_pkg::*;

class token_scoreboard;
  fud_res_t   expected_results[$];
  fud_res_t   burst[$];
  logic [1:0] esc_phase;
  logic [7:0] held_digit;
  bit         in_value;
  bit         token_open;
  int         failures;

  function new();
    esc_phase  = ESC_IDLE;
    held_digit = 8'h00;
    in_value   = 1'b0;
    token_open = 1'b0;
    failures   = 0;
  endfunction

  function bit is_hex_digit(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function logic [3:0] nibble_of(logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") v = c - "0";
    else if (c >= "a") v = c - "a" + 8'd10;
    else v = c - "A" + 8'd10;
    return v[3:0];
  endfunction

  function void add_result(logic [7:0] d, logic [1:0] k);
    fud_res_t r;
    r.data = d;
    r.kind = k;
    r.last = 1'b0;
    if (burst.size() < MAX_RES) burst.push_back(r);
  endfunction

  // The first decoded '=' of a token is swallowed and opens the value part.
  function void emit_decoded(logic [7:0] d);
    if (!in_value && d == CHAR_EQUAL) begin
      in_value = 1'b1;
      return;
    end
    add_result(d, in_value ? KIND_VALUE : KIND_NAME);
  endfunction

  function void flush_escape();
    if (esc_phase == ESC_PCT) begin
      emit_decoded(CHAR_PERCENT);
    end else if (esc_phase == ESC_DIGIT) begin
      emit_decoded(CHAR_PERCENT);
      emit_decoded(held_digit);
    end
    esc_phase  = ESC_IDLE;
    held_digit = 8'h00;
  endfunction

  function void close_token();
    if (token_open) add_result(8'h00, in_value ? KIND_ACCEPT : KIND_DISCARD);
    token_open = 1'b0;
    in_value   = 1'b0;
  endfunction

  function void take_plain(logic [7:0] b);
    if (b == CHAR_AMP) begin
      close_token();
      return;
    end
    token_open = 1'b1;
    if (b == CHAR_PERCENT) esc_phase = ESC_PCT;
    else if (b == CHAR_PLUS) emit_decoded(CHAR_SPACE);
    else emit_decoded(b);
  endfunction

  function void note_request(logic [7:0] b, logic l);
    fud_res_t r;
    burst.delete();
    if (esc_phase == ESC_PCT && is_hex_digit(b)) begin
      held_digit = b;
      esc_phase  = ESC_DIGIT;
    end else if (esc_phase == ESC_DIGIT && is_hex_digit(b)) begin
      esc_phase = ESC_IDLE;
      emit_decoded({nibble_of(held_digit), nibble_of(b)});
      held_digit = 8'h00;
    end else begin
      flush_escape();
      take_plain(b);
    end
    if (l) begin
      flush_escape();
      close_token();
    end
    if (burst.size() > 0) begin
      r = burst[burst.size() - 1];
      r.last = 1'b1;
      burst[burst.size() - 1] = r;
    end
    foreach (burst[i]) expected_results.push_back(burst[i]);
  endfunction

  function void check_result(logic [7:0] b, logic [1:0] k, logic l);
    fud_res_t exp_res;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: out_byte %h kind %0d out_last %0b", b, k, l);
      failures++;
      return;
    end
    exp_res = expected_results.pop_front();
    if (b !== exp_res.data) begin
      $error("out_byte mismatch: expected %h, got %h", exp_res.data, b);
      failures++;
    end
    if (k !== exp_res.kind) begin
      $error("kind mismatch: expected %0d, got %0d", exp_res.kind, k);
      failures++;
    end
    if (l !== exp_res.last) begin
      $error("out_last mismatch: expected %0b, got %0b", exp_res.last, l);
      failures++;
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_form_urlencoded_decoder_core;
  // Generous bound, even with heavy stalls.
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 80;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       out_last;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int cycle_count = 0;
  int sent_total  = 0;

  logic [7:0]     body_bytes[$];
  token_scoreboard board;

  form_urlencoded_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .kind      (kind),
    .out_last  (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bound the run; a hang on either channel ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: check every result taken at this edge, then pick the stall
  // for the next cycle. Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) board.check_result(out_byte, kind, out_last);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one request, idling first at random. Hold the payload until the
  // block takes it, then log it with the scoreboard.
  task automatic send_request(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    do @(posedge clk); while (in_stall);
    board.note_request(b, l);
    sent_total++;
  endtask

  task automatic send_text(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++) send_request(s[i], last_at_end && i == s.len() - 1);
  endtask

  // Push one hex digit, letters in random case.
  function automatic void push_hex_digit();
    int v;
    v = $urandom_range(15);
    if (v < 10) body_bytes.push_back(8'(v) + "0");
    else body_bytes.push_back(8'(v - 10) + ($urandom_range(1) ? "A" : "a"));
  endfunction

  // Push one unit of token text: mostly printable bytes, plus '+', good and
  // broken escapes, raw '=' and arbitrary bytes.
  function automatic void add_unit();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      body_bytes.push_back(8'($urandom_range(33, 126)));
    end else if (r < 55) begin
      body_bytes.push_back(CHAR_PLUS);
    end else if (r < 72) begin
      body_bytes.push_back(CHAR_PERCENT);
      push_hex_digit();
      push_hex_digit();
    end else if (r < 80) begin
      body_bytes.push_back(CHAR_PERCENT);
      if ($urandom_range(1)) push_hex_digit();
      body_bytes.push_back(8'($urandom_range(255)));
    end else if (r < 88) begin
      body_bytes.push_back(CHAR_EQUAL);
    end else begin
      body_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  // Build a mostly well-formed body of name=value tokens and send it,
  // usually flagging the final byte as the end of the body.
  task automatic send_body();
    int ntok;
    bit end_last;
    body_bytes.delete();
    ntok = $urandom_range(1, 4);
    for (int t = 0; t < ntok; t++) begin
      repeat ($urandom_range(0, 4)) add_unit();
      if ($urandom_range(99) < 75) begin
        // Split either by a raw '=' or by an escaped one.
        if ($urandom_range(3) == 0) begin
          body_bytes.push_back(CHAR_PERCENT);
          body_bytes.push_back("3");
          body_bytes.push_back($urandom_range(1) ? "D" : "d");
        end else begin
          body_bytes.push_back(CHAR_EQUAL);
        end
        repeat ($urandom_range(0, 5)) add_unit();
      end
      if (t < ntok - 1) begin
        body_bytes.push_back(CHAR_AMP);
        if ($urandom_range(4) == 0) body_bytes.push_back(CHAR_AMP);
      end
    end
    if (body_bytes.size() == 0) body_bytes.push_back(CHAR_AMP);
    end_last = ($urandom_range(99) < 80);
    foreach (body_bytes[i]) send_request(body_bytes[i], end_last && i == body_bytes.size() - 1);
  endtask

  // Arbitrary bytes with a scattered end-of-body flag.
  task automatic send_noise();
    repeat ($urandom_range(1, 8)) send_request(8'($urandom_range(255)), $urandom_range(9) == 0);
  endtask

  initial begin
    int phase_start;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: pair with '+', empty token, escaped '=' and both hex cases,
    // broken escapes after '%' and after one digit, an escape cut by '&',
    // zero and all-ones bytes, an escape flushed at end of body, and an
    // end of body with no open token.
    send_text("n=+&", 1'b0);
    send_text("&", 1'b0);
    send_text("%3d%4A&", 1'b0);
    send_text("%g%4Z%4&", 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(CHAR_PERCENT, 1'b1);
    send_request(CHAR_AMP, 1'b1);

    // Random bodies through four idle/stall phases.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 69;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 69;
        end
        default: begin
          idle_pct  = 19;
          stall_pct = 19;
        end
      endcase
      phase_start = sent_total;
      while (sent_total - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 15) send_noise();
        else send_body();
      end
    end
    in_valid <= 1'b0;

    // Drain, then wait for any stray result to show up.
    while (board.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/fud_pkg.sv
rtl/fud_decode.sv
rtl/fud_queue.sv
rtl/form_urlencoded_decoder_core.sv
test/tb_form_urlencoded_decoder_core.sv
